// ===== src/dsq_pkg.sv =====
// Package for the deduplicating slot queue: request and response words,
// status and request codes, configuration indexes and the chain command.
// No dependencies.
package dsq_pkg;

	// request codes
	localparam logic [1:0] REQ_ENQUEUE = 2'd0;
	localparam logic [1:0] REQ_REMOVE  = 2'd1;
	localparam logic [1:0] REQ_CLEAR   = 2'd2;

	// status codes
	localparam logic [2:0] ST_QUEUED  = 3'd0;
	localparam logic [2:0] ST_DUP     = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_STORE   = 3'd4;
	localparam logic [2:0] ST_REMOVED = 3'd5;
	localparam logic [2:0] ST_STALE   = 3'd6;
	localparam logic [2:0] ST_CLEARED = 3'd7;

	// configuration register indexes
	localparam logic [0:0] CFG_EXPECTED_NODE  = 1'b0;
	localparam logic [0:0] CFG_REQUIRED_FLAGS = 1'b1;

	localparam logic [15:0] EXPECTED_NODE_RST  = 16'd1;
	localparam logic [7:0]  REQUIRED_FLAGS_RST = 8'd15;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] node_id;
		logic [31:0] message_id;
		logic [7:0]  valid_flags;
		logic        values_in_range;
		logic [4:0]  target_slot;
		logic [31:0] expected_seq;
		logic [31:0] expected_gen;
		logic        store_ok;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [4:0]  used_slot;
		logic [31:0] given_seq;
		logic [31:0] gen_now;
		logic [5:0]  pending;
		logic        front_valid;
		logic [4:0]  front_slot;
		logic [31:0] front_seq;
		logic [31:0] front_message;
	} rsp_t;

	// one action for the whole row of cells in a cycle
	typedef struct packed {
		logic insert;
		logic shift;
		logic wipe;
	} chain_cmd_t;

endpackage

// ===== src/dsq_cell.sv =====
// One cell of the sorted record row: holds one record and its sort key.
// Depends on dsq_pkg (chain_cmd_t).
module dsq_cell #(
	parameter int SLOT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dsq_pkg::chain_cmd_t cmd,
	input  logic [SLOT_W-1:0]   new_slot,
	input  logic [15:0]         new_node,
	input  logic [31:0]         new_msg,
	input  logic [31:0]         new_seq,
	input  logic                left_lt,
	input  logic                left_valid,
	input  logic [SLOT_W-1:0]   left_slot,
	input  logic [15:0]         left_node,
	input  logic [31:0]         left_msg,
	input  logic [31:0]         left_seq,
	input  logic                right_valid,
	input  logic [SLOT_W-1:0]   right_slot,
	input  logic [15:0]         right_node,
	input  logic [31:0]         right_msg,
	input  logic [31:0]         right_seq,
	output logic                valid_q,
	output logic [SLOT_W-1:0]   slot_q,
	output logic [15:0]         node_q,
	output logic [31:0]         msg_q,
	output logic [31:0]         seq_q,
	output logic                lt,
	output logic                hit
);

	logic take_new;
	logic take_left;

	// order by sequence, then by slot index
	assign lt  = valid_q && ({seq_q, slot_q} < {new_seq, new_slot});
	assign hit = valid_q && (node_q == new_node) && (msg_q == new_msg);

	assign take_new  = cmd.insert && !lt && left_lt;
	assign take_left = cmd.insert && !lt && !left_lt;

	// hold occupancy; clear on wipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (cmd.wipe) begin
			valid_q <= 1'b0;
		end else if (cmd.shift) begin
			valid_q <= right_valid;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (take_left) begin
			valid_q <= left_valid;
		end
	end

	// advance record contents
	always_ff @(posedge clk) begin
		if (cmd.shift) begin
			slot_q <= right_slot;
			node_q <= right_node;
			msg_q  <= right_msg;
			seq_q  <= right_seq;
		end else if (take_new) begin
			slot_q <= new_slot;
			node_q <= new_node;
			msg_q  <= new_msg;
			seq_q  <= new_seq;
		end else if (take_left) begin
			slot_q <= left_slot;
			node_q <= left_node;
			msg_q  <= left_msg;
			seq_q  <= left_seq;
		end
	end

endmodule

// ===== src/dsq_chain.sv =====
// Row of record cells kept sorted by (sequence, slot); front sits in cell 0.
// Depends on dsq_pkg and dsq_cell.
module dsq_chain #(
	parameter int DEPTH  = 32,
	parameter int SLOT_W = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dsq_pkg::chain_cmd_t cmd,
	input  logic [SLOT_W-1:0]   new_slot,
	input  logic [15:0]         new_node,
	input  logic [31:0]         new_msg,
	input  logic [31:0]         new_seq,
	output logic                front_valid,
	output logic [SLOT_W-1:0]   front_slot,
	output logic [31:0]         front_seq,
	output logic [31:0]         front_msg,
	output logic                dup
);

	logic              c_valid [DEPTH];
	logic [SLOT_W-1:0] c_slot  [DEPTH];
	logic [15:0]       c_node  [DEPTH];
	logic [31:0]       c_msg   [DEPTH];
	logic [31:0]       c_seq   [DEPTH];
	logic              c_lt    [DEPTH];
	logic [DEPTH-1:0]  c_hit;

	logic              l_lt    [DEPTH];
	logic              l_valid [DEPTH];
	logic [SLOT_W-1:0] l_slot  [DEPTH];
	logic [15:0]       l_node  [DEPTH];
	logic [31:0]       l_msg   [DEPTH];
	logic [31:0]       l_seq   [DEPTH];
	logic              r_valid [DEPTH];
	logic [SLOT_W-1:0] r_slot  [DEPTH];
	logic [15:0]       r_node  [DEPTH];
	logic [31:0]       r_msg   [DEPTH];
	logic [31:0]       r_seq   [DEPTH];

	// neighbor wiring; the head sees a smaller key, the tail sees an empty cell
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (i == 0) begin
				l_lt[i]    = 1'b1;
				l_valid[i] = 1'b0;
				l_slot[i]  = '0;
				l_node[i]  = '0;
				l_msg[i]   = '0;
				l_seq[i]   = '0;
			end else begin
				l_lt[i]    = c_lt[i-1];
				l_valid[i] = c_valid[i-1];
				l_slot[i]  = c_slot[i-1];
				l_node[i]  = c_node[i-1];
				l_msg[i]   = c_msg[i-1];
				l_seq[i]   = c_seq[i-1];
			end
			if (i == DEPTH - 1) begin
				r_valid[i] = 1'b0;
				r_slot[i]  = '0;
				r_node[i]  = '0;
				r_msg[i]   = '0;
				r_seq[i]   = '0;
			end else begin
				r_valid[i] = c_valid[i+1];
				r_slot[i]  = c_slot[i+1];
				r_node[i]  = c_node[i+1];
				r_msg[i]   = c_msg[i+1];
				r_seq[i]   = c_seq[i+1];
			end
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dsq_cell #(.SLOT_W(SLOT_W)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.new_slot   (new_slot),
			.new_node   (new_node),
			.new_msg    (new_msg),
			.new_seq    (new_seq),
			.left_lt    (l_lt[g]),
			.left_valid (l_valid[g]),
			.left_slot  (l_slot[g]),
			.left_node  (l_node[g]),
			.left_msg   (l_msg[g]),
			.left_seq   (l_seq[g]),
			.right_valid(r_valid[g]),
			.right_slot (r_slot[g]),
			.right_node (r_node[g]),
			.right_msg  (r_msg[g]),
			.right_seq  (r_seq[g]),
			.valid_q    (c_valid[g]),
			.slot_q     (c_slot[g]),
			.node_q     (c_node[g]),
			.msg_q      (c_msg[g]),
			.seq_q      (c_seq[g]),
			.lt         (c_lt[g]),
			.hit        (c_hit[g])
		);
	end

	assign front_valid = c_valid[0];
	assign front_slot  = c_slot[0];
	assign front_seq   = c_seq[0];
	assign front_msg   = c_msg[0];
	assign dup         = |c_hit;

endmodule

// ===== src/dedup_slot_queue.sv =====
// Top level of the deduplicating slot queue: request decode, slot bitmap,
// counters, configuration and response register. Depends on dsq_pkg, dsq_chain.
//
//  channel | handshake               | word
//  --------+-------------------------+-----------------------------------
//  request | req_valid / req_ready   | req  (dsq_pkg::req_t)
//  result  | rsp_valid / rsp_ready   | rsp  (dsq_pkg::rsp_t)
//  config  | cfg_we (no wait)        | cfg_addr, cfg_wdata
//
// Each request is first registered, then executes with every cell of the
// record row comparing its key and shifting or holding in parallel.
// One request is in flight at a time; a result waiting on rsp_ready holds
// the next registered request from executing.
// Reset clears the cell valid bits, the slot bitmap and the count and sets
// the sequence and generation to one at once; no clearing pass is needed.
module dedup_slot_queue #(
	parameter int QUEUE_DEPTH = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  dsq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output dsq_pkg::rsp_t rsp,
	input  logic          cfg_we,
	input  logic [0:0]    cfg_addr,
	input  logic [15:0]   cfg_wdata
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W  = (SLOT_W > 5) ? SLOT_W : 5;

	logic [15:0]            expected_node_q;
	logic [7:0]             required_flags_q;
	dsq_pkg::req_t          req_s1;
	logic                   req_valid_s1;
	logic                   rsp_valid_q;
	logic [2:0]             status_q;
	logic [4:0]             used_slot_q;
	logic [31:0]            given_seq_q;
	logic [QUEUE_DEPTH-1:0] used_q;
	logic [CNT_W-1:0]       count_q;
	logic [31:0]            next_seq_q;
	logic [31:0]            gen_q;

	logic                   fire;
	logic                   enq_ok;
	logic                   stale;
	logic                   full;
	logic [QUEUE_DEPTH-1:0] free_vec;
	logic [QUEUE_DEPTH-1:0] free_hot;
	logic [SLOT_W-1:0]      free_slot;
	logic [2:0]             nx_status;
	dsq_pkg::chain_cmd_t    act;
	dsq_pkg::chain_cmd_t    cmd;
	logic                   front_valid;
	logic [SLOT_W-1:0]      front_slot;
	logic [31:0]            front_seq;
	logic [31:0]            front_msg;
	logic                   dup;

	assign req_ready = !req_valid_s1;
	assign fire      = req_valid_s1 && (!rsp_valid_q || rsp_ready);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_node_q  <= dsq_pkg::EXPECTED_NODE_RST;
			required_flags_q <= dsq_pkg::REQUIRED_FLAGS_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				dsq_pkg::CFG_EXPECTED_NODE:  expected_node_q  <= cfg_wdata;
				dsq_pkg::CFG_REQUIRED_FLAGS: required_flags_q <= cfg_wdata[7:0];
				default: ;
			endcase
		end
	end

	// lowest free slot: isolate the lowest zero of the bitmap, then encode
	assign free_vec = ~used_q;
	assign free_hot = free_vec & (~free_vec + {{(QUEUE_DEPTH-1){1'b0}}, 1'b1});
	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));

	always_comb begin
		free_slot = '0;
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			free_slot = free_slot | (free_hot[i] ? SLOT_W'(i) : '0);
		end
	end

	// validate and decide
	assign enq_ok = (req_s1.node_id == expected_node_q) && (req_s1.message_id != '0)
		&& ((req_s1.valid_flags & required_flags_q) == required_flags_q)
		&& req_s1.values_in_range;

	assign stale = (req_s1.expected_gen != gen_q) || !front_valid
		|| (CMP_W'(front_slot) != CMP_W'(req_s1.target_slot))
		|| (front_seq != req_s1.expected_seq) || (front_msg != req_s1.message_id);

	always_comb begin
		act       = '0;
		nx_status = dsq_pkg::ST_INVALID;
		case (req_s1.req_type)
			dsq_pkg::REQ_ENQUEUE: begin
				if (!enq_ok) begin
					nx_status = dsq_pkg::ST_INVALID;
				end else if (dup) begin
					nx_status = dsq_pkg::ST_DUP;
				end else if (full) begin
					nx_status = dsq_pkg::ST_FULL;
				end else if (!req_s1.store_ok) begin
					nx_status = dsq_pkg::ST_STORE;
				end else begin
					nx_status  = dsq_pkg::ST_QUEUED;
					act.insert = 1'b1;
				end
			end
			dsq_pkg::REQ_REMOVE: begin
				if (stale) begin
					nx_status = dsq_pkg::ST_STALE;
				end else if (!req_s1.store_ok) begin
					nx_status = dsq_pkg::ST_STORE;
				end else begin
					nx_status = dsq_pkg::ST_REMOVED;
					act.shift = 1'b1;
				end
			end
			dsq_pkg::REQ_CLEAR: begin
				if (!req_s1.store_ok) begin
					nx_status = dsq_pkg::ST_STORE;
				end else begin
					nx_status = dsq_pkg::ST_CLEARED;
					act.wipe  = 1'b1;
				end
			end
			default: nx_status = dsq_pkg::ST_INVALID;
		endcase
	end

	assign cmd = fire ? act : '0;

	dsq_chain #(.DEPTH(QUEUE_DEPTH), .SLOT_W(SLOT_W)) u_chain (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.new_slot   (free_slot),
		.new_node   (req_s1.node_id),
		.new_msg    (req_s1.message_id),
		.new_seq    (next_seq_q),
		.front_valid(front_valid),
		.front_slot (front_slot),
		.front_seq  (front_seq),
		.front_msg  (front_msg),
		.dup        (dup)
	);

	// hold the request word until it executes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid_s1 <= 1'b0;
		end else if (req_valid && req_ready) begin
			req_valid_s1 <= 1'b1;
		end else if (fire) begin
			req_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
	end

	// update bitmap, counters and generation
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q     <= '0;
			count_q    <= '0;
			next_seq_q <= 32'd1;
			gen_q      <= 32'd1;
		end else if (cmd.insert) begin
			used_q     <= used_q | free_hot;
			count_q    <= count_q + CNT_W'(1);
			if (next_seq_q != '1) begin
				next_seq_q <= next_seq_q + 32'd1;
			end
		end else if (cmd.shift) begin
			used_q[front_slot] <= 1'b0;
			count_q            <= count_q - CNT_W'(1);
		end else if (cmd.wipe) begin
			used_q     <= '0;
			count_q    <= '0;
			next_seq_q <= 32'd1;
			gen_q      <= (gen_q == '1) ? 32'd1 : gen_q + 32'd1;
		end
	end

	// load the result; state registers feed the rest of the word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (fire) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= nx_status;
			used_slot_q <= act.insert ? 5'(free_slot) : (act.shift ? 5'(front_slot) : 5'd0);
			given_seq_q <= act.insert ? next_seq_q : 32'd0;
		end
	end

	assign rsp_valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.used_slot     = used_slot_q;
	assign rsp.given_seq     = given_seq_q;
	assign rsp.gen_now       = gen_q;
	assign rsp.pending       = 6'(count_q);
	assign rsp.front_valid   = front_valid;
	assign rsp.front_slot    = front_valid ? 5'(front_slot) : 5'd0;
	assign rsp.front_seq     = front_valid ? front_seq : 32'd0;
	assign rsp.front_message = front_valid ? front_msg : 32'd0;

	// occupancy count tracks the slot bitmap
	a_count_bitmap: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q))
		else $error("count and bitmap disagree");

	// the row is nonempty exactly when the count is nonzero
	a_front_count: assert property (@(posedge clk) disable iff (!arst_n)
		front_valid == (count_q != '0))
		else $error("front valid and count disagree");

	// a queued record raises the count by one
	a_queue_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.insert |=> int'(count_q) == int'($past(count_q)) + 1)
		else $error("queued record did not raise the count");

	// the generation never reads zero
	a_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != '0)
		else $error("generation is zero");

endmodule
